// ===== hdl/sdst_pkg.sv =====
// ----------------------------------------------------------------------------
// sdst_pkg: shared definitions for the sorted date set table
// sizes, operation and search codes, and the structs passed between the
// compare cells, the group reducers and the control logic
// ----------------------------------------------------------------------------
package sdst_pkg;

   localparam int TABLE_DEPTH  = 256;
   localparam int DAY_BITS     = 24;
   localparam int IDX_BITS     = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS     = IDX_BITS + 1;
   localparam int POS_BITS     = 8;
   localparam int HELD_BITS    = 9;
   localparam int GROUP_SIZE   = (TABLE_DEPTH < 16) ? TABLE_DEPTH : 16;
   localparam int GROUP_COUNT  = TABLE_DEPTH / GROUP_SIZE;

   // operation codes
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_DELETE = 2'd1;
   localparam logic [1:0] FUNC_SEARCH = 2'd2;

   // search modes
   localparam logic [1:0] MODE_EXACT   = 2'd0;
   localparam logic [1:0] MODE_EARLIER = 2'd1;
   localparam logic [1:0] MODE_LATER   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CMP  = 4'b0010,
      ST_GRP  = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   // broadcast control to every cell
   typedef struct packed {
      logic cmp_en;
      logic ins_go;
      logic del_go;
   } cell_ctrl_type;

   // per-group summary of the compare flags
   typedef struct packed {
      logic                any_edge;
      logic [IDX_BITS-1:0] edge_idx;
      logic                hit;
   } grp_sum_type;

endpackage

// ===== hdl/sdst_cell.sv =====
// ----------------------------------------------------------------------------
// sdst_cell: one table entry
// holds a day number, compares it against the broadcast day, and shifts
// toward or away from its neighbors on insert and delete
// ----------------------------------------------------------------------------
module sdst_cell (
   input  logic                              clock,
   input  sdst_pkg::cell_ctrl_type           ctrl,
   input  logic [sdst_pkg::IDX_BITS-1:0]     cell_index,
   input  logic [sdst_pkg::CNT_BITS-1:0]     count,
   input  logic [sdst_pkg::DAY_BITS-1:0]     day,
   input  logic [sdst_pkg::DAY_BITS-1:0]     left_value,
   input  logic                              left_lt,
   input  logic [sdst_pkg::DAY_BITS-1:0]     right_value,
   output logic [sdst_pkg::DAY_BITS-1:0]     value,
   output logic                              lt,
   output logic                              eq
);

   logic [sdst_pkg::DAY_BITS-1:0] value_ff, value_in;
   logic                          lt_ff, lt_in;
   logic                          eq_ff, eq_in;
   logic [sdst_pkg::CNT_BITS-1:0] idx_ext;
   logic                          occupied;

   assign idx_ext  = {1'b0, cell_index};
   assign occupied = idx_ext < count;

   always_comb begin
      value_in = value_ff;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      if (ctrl.cmp_en) begin
         lt_in = occupied && (value_ff < day);
         eq_in = occupied && (value_ff == day);
      end
      // insert: cells at or above the slot move up one place
      if (ctrl.ins_go && !lt_ff && (idx_ext <= count)) begin
         value_in = left_lt ? day : left_value;
      end
      // delete: cells from the hit upward pull from the right
      if (ctrl.del_go && !lt_ff && ((idx_ext + sdst_pkg::CNT_BITS'(1)) < count)) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

   assign value = value_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

endmodule

// ===== hdl/sdst_group.sv =====
// ----------------------------------------------------------------------------
// sdst_group: registered summary of one group of cells
// finds the boundary where the below-flags end, and any equal hit
// ----------------------------------------------------------------------------
module sdst_group (
   input  logic                                clock,
   input  logic [sdst_pkg::GROUP_SIZE-1:0]     lt,
   input  logic                                lt_prev,
   input  logic [sdst_pkg::GROUP_SIZE-1:0]     eq,
   input  logic [sdst_pkg::IDX_BITS-1:0]       base,
   output sdst_pkg::grp_sum_type               summary
);

   sdst_pkg::grp_sum_type sum_ff, sum_in;

   always_comb begin
      logic prev;
      prev = 1'b0;
      sum_in.any_edge = 1'b0;
      sum_in.edge_idx = '0;
      sum_in.hit      = |eq;
      for (int j = 0; j < sdst_pkg::GROUP_SIZE; j++) begin
         prev = (j == 0) ? lt_prev : lt[j-1];
         // at most one boundary in the whole table, so an or is enough
         if (prev && !lt[j]) begin
            sum_in.any_edge = 1'b1;
            sum_in.edge_idx = sum_in.edge_idx | (base + sdst_pkg::IDX_BITS'(j));
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign summary = sum_ff;

endmodule

// ===== hdl/sorted_date_set_table.sv =====
// ----------------------------------------------------------------------------
// sorted_date_set_table: ascending duplicate-free table of day numbers
// a row of compare/shift cells with insert, delete and three-mode search
// ----------------------------------------------------------------------------
// sequence: an item is taken while idle, then goes through compare, group
//   reduce, and final reduce and shift; no new item is taken until its result
//   is loaded, which waits while a held result is stalled by rsp_stall
// reset: synchronous; clears the fill count and handshake state only, the
//   cell contents are left as they are and no clearing pass is run
// ----------------------------------------------------------------------------
module sorted_date_set_table (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_func,
   input  logic [sdst_pkg::DAY_BITS-1:0]      req_day_value,
   input  logic [1:0]                         req_search_mode,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_found,
   output logic [sdst_pkg::POS_BITS-1:0]      rsp_position,
   output logic [sdst_pkg::HELD_BITS-1:0]     rsp_entries_held,
   output logic                               rsp_status
);

   localparam int DEPTH = sdst_pkg::TABLE_DEPTH;
   localparam int GS    = sdst_pkg::GROUP_SIZE;
   localparam int GC    = sdst_pkg::GROUP_COUNT;

   // control state
   sdst_pkg::state_type            state_ff, state_in;
   logic [sdst_pkg::CNT_BITS-1:0]  count_ff, count_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // item held while it is worked on
   logic [1:0]                     func_ff, func_in;
   logic [sdst_pkg::DAY_BITS-1:0]  day_ff, day_in;
   logic [1:0]                     mode_ff, mode_in;

   // result register
   logic                           found_ff, found_in;
   logic [sdst_pkg::POS_BITS-1:0]  pos_ff, pos_in;
   logic [sdst_pkg::HELD_BITS-1:0] held_ff, held_in;
   logic                           status_ff, status_in;

   // cell row
   sdst_pkg::cell_ctrl_type        cell_ctrl;
   logic [sdst_pkg::DAY_BITS-1:0]  cell_value [DEPTH];
   logic [DEPTH-1:0]               cell_lt;
   logic [DEPTH-1:0]               cell_eq;
   sdst_pkg::grp_sum_type          grp_sum [GC];

   // final reduction
   logic                           any_edge;
   logic [sdst_pkg::IDX_BITS-1:0]  edge_idx;
   logic                           hit;
   logic [sdst_pkg::CNT_BITS-1:0]  below_cnt;
   logic [sdst_pkg::CNT_BITS-1:0]  lo_raw, lo, n_m2, pick;
   logic                           accept, slot_free, commit;
   logic                           ins_go, del_go, ins_full;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != sdst_pkg::ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == sdst_pkg::ST_FIN) && slot_free;

   // ------------------------------------------------------------------
   // cell row: each cell sees its left and right neighbor
   // ------------------------------------------------------------------
   assign cell_ctrl.cmp_en = (state_ff == sdst_pkg::ST_CMP);
   assign cell_ctrl.ins_go = commit && ins_go;
   assign cell_ctrl.del_go = commit && del_go;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [sdst_pkg::DAY_BITS-1:0] left_value;
      logic                          left_lt;
      logic [sdst_pkg::DAY_BITS-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = '0;
         assign left_lt    = 1'b1;
      end else begin : g_mid
         assign left_value = cell_value[i-1];
         assign left_lt    = cell_lt[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end

      sdst_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .cell_index  (sdst_pkg::IDX_BITS'(i)),
         .count       (count_ff),
         .day         (day_ff),
         .left_value  (left_value),
         .left_lt     (left_lt),
         .right_value (right_value),
         .value       (cell_value[i]),
         .lt          (cell_lt[i]),
         .eq          (cell_eq[i])
      );
   end

   // ------------------------------------------------------------------
   // group summaries, registered in the cycle after the compare flags
   // ------------------------------------------------------------------
   for (genvar g = 0; g < GC; g++) begin : g_group
      logic lt_prev;

      if (g == 0) begin : g_first
         assign lt_prev = 1'b1;
      end else begin : g_rest
         assign lt_prev = cell_lt[g*GS-1];
      end

      sdst_group u_group (
         .clock   (clock),
         .lt      (cell_lt[g*GS +: GS]),
         .lt_prev (lt_prev),
         .eq      (cell_eq[g*GS +: GS]),
         .base    (sdst_pkg::IDX_BITS'(g*GS)),
         .summary (grp_sum[g])
      );
   end

   // or the group summaries together; no boundary means every entry is below
   always_comb begin
      any_edge = 1'b0;
      edge_idx = '0;
      hit      = 1'b0;
      for (int g = 0; g < GC; g++) begin
         any_edge = any_edge | grp_sum[g].any_edge;
         edge_idx = edge_idx | grp_sum[g].edge_idx;
         hit      = hit | grp_sum[g].hit;
      end
   end

   assign below_cnt = any_edge ? {1'b0, edge_idx} : sdst_pkg::CNT_BITS'(DEPTH);

   // ------------------------------------------------------------------
   // operation decode
   // ------------------------------------------------------------------
   assign ins_go   = (func_ff == sdst_pkg::FUNC_INSERT) && !hit &&
                     (count_ff < sdst_pkg::CNT_BITS'(DEPTH));
   assign ins_full = (func_ff == sdst_pkg::FUNC_INSERT) && !hit &&
                     (count_ff >= sdst_pkg::CNT_BITS'(DEPTH));
   assign del_go   = (func_ff == sdst_pkg::FUNC_DELETE) && hit;

   // rounding pair from the search end point: lo = min(max(k-1,0), n-2)
   assign lo_raw = (below_cnt != '0) ? (below_cnt - sdst_pkg::CNT_BITS'(1)) : '0;
   assign n_m2   = count_ff - sdst_pkg::CNT_BITS'(2);
   assign lo     = (lo_raw > n_m2) ? n_m2 : lo_raw;
   assign pick   = (mode_ff == sdst_pkg::MODE_EARLIER) ? lo : (lo + sdst_pkg::CNT_BITS'(1));

   always_comb begin
      logic [sdst_pkg::CNT_BITS-1:0] next_cnt;
      next_cnt = count_ff;
      if (ins_go) begin
         next_cnt = count_ff + sdst_pkg::CNT_BITS'(1);
      end else if (del_go) begin
         next_cnt = count_ff - sdst_pkg::CNT_BITS'(1);
      end

      found_in  = found_ff;
      pos_in    = pos_ff;
      held_in   = held_ff;
      status_in = status_ff;
      count_in  = count_ff;

      if (commit) begin
         count_in  = next_cnt;
         held_in   = sdst_pkg::HELD_BITS'(next_cnt);
         status_in = ins_full;
         found_in  = 1'b0;
         pos_in    = '0;
         unique case (func_ff) inside
            sdst_pkg::FUNC_SEARCH: begin
               if (count_ff == '0) begin
                  // empty table: never found
                  found_in = 1'b0;
               end else if (hit) begin
                  found_in = 1'b1;
                  pos_in   = sdst_pkg::POS_BITS'(below_cnt);
               end else if (mode_ff == sdst_pkg::MODE_EXACT) begin
                  found_in = 1'b0;
               end else if (count_ff == sdst_pkg::CNT_BITS'(1)) begin
                  // single entry rounds to itself
                  found_in = 1'b1;
               end else begin
                  found_in = 1'b1;
                  pos_in   = sdst_pkg::POS_BITS'(pick);
               end
            end
            sdst_pkg::FUNC_INSERT,
            sdst_pkg::FUNC_DELETE: begin
               found_in = 1'b0;
            end
            default: begin
               // unused operation: report only the count
               found_in = 1'b0;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // sequencer: take item, compare, group reduce, finish
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sdst_pkg::ST_IDLE: if (accept)    state_in = sdst_pkg::ST_CMP;
         sdst_pkg::ST_CMP:                 state_in = sdst_pkg::ST_GRP;
         sdst_pkg::ST_GRP:                 state_in = sdst_pkg::ST_FIN;
         sdst_pkg::ST_FIN:  if (slot_free) state_in = sdst_pkg::ST_IDLE;
         default:                          state_in = sdst_pkg::ST_IDLE;
      endcase
   end

   // item capture
   assign func_in = accept ? req_func        : func_ff;
   assign day_in  = accept ? req_day_value   : day_ff;
   assign mode_in = accept ? req_search_mode : mode_ff;

   // result handshake: load on finish, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdst_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      day_ff    <= day_in;
      mode_ff   <= mode_in;
      found_ff  <= found_in;
      pos_ff    <= pos_in;
      held_ff   <= held_in;
      status_ff <= status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = found_ff;
   assign rsp_position     = pos_ff;
   assign rsp_entries_held = held_ff;
   assign rsp_status       = status_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sdst_pkg::CNT_BITS'(DEPTH))
      else $error("fill count above table depth");

   a_one_change: assert property (@(posedge clock) disable iff (reset)
      commit |-> !(ins_go && del_go))
      else $error("insert and delete on the same item");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (commit && ins_go) |=> (count_ff == $past(count_ff) + sdst_pkg::CNT_BITS'(1)))
      else $error("insert did not grow the table");

   a_refused_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (!rsp_found && (rsp_position == '0)))
      else $error("refused insert reports a search result");

   a_found_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |->
         (sdst_pkg::HELD_BITS'(rsp_position) < rsp_entries_held))
      else $error("found position outside held entries");

endmodule
